[rtl/core/fate_pkg.sv]
// Shared types, codes and constants of the FAT table entry engine.
package fate_pkg;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_GET  = 3'd2;
  localparam logic [2:0] OP_SET  = 3'd3;
  localparam logic [2:0] OP_FIND = 3'd4;

  localparam logic [2:0] ST_LINK   = 3'd0;
  localparam logic [2:0] ST_BAD    = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_UNUSED = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;
  localparam logic [2:0] ST_NONE   = 3'd5;

  localparam logic [1:0] KIND_LINK   = 2'd0;
  localparam logic [1:0] KIND_BAD    = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] FAT12       = 2'd0;
  localparam logic [1:0] FAT16       = 2'd1;
  localparam logic [1:0] FAT32       = 2'd2;
  localparam logic [1:0] FAT_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_FAT_TYPE      = 2'd0;
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;

  localparam logic [27:0] BAD12 = 28'h0000FF7;
  localparam logic [27:0] END12 = 28'h0000FF8;
  localparam logic [27:0] BAD16 = 28'h000FFF7;
  localparam logic [27:0] END16 = 28'h000FFF8;
  localparam logic [27:0] BAD32 = 28'hFFFFFF7;
  localparam logic [27:0] END32 = 28'hFFFFFF8;
  localparam logic [31:0] MASK28 = 32'h0FFFFFFF;
  localparam logic [15:0] MASK12 = 16'h0FFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [13:0] byte_address;
    logic [7:0]  byte_data;
    logic [13:0] cluster_index;
    logic [27:0] entry_value;
    logic [1:0]  value_kind;
    logic        byte_range;   // byte address beyond the store
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

[rtl/core/fate_if.sv]
// Channel interfaces: request, response and configuration write.
interface fate_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [13:0] byte_address;
  logic [7:0]  byte_data;
  logic [13:0] cluster_index;
  logic [27:0] entry_value;
  logic [1:0]  value_kind;
  modport source (output valid, op, byte_address, byte_data, cluster_index,
                  entry_value, value_kind, input ready);
  modport sink (input valid, op, byte_address, byte_data, cluster_index,
                entry_value, value_kind, output ready);
endinterface

interface fate_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [27:0] cluster_value;
  logic [7:0]  byte_out;
  modport source (output valid, status, cluster_value, byte_out, input ready);
  modport sink (input valid, status, cluster_value, byte_out, output ready);
endinterface

interface fate_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/fate_ram.sv]
// Generic single-port RAM with registered read.
module fate_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/core/fate_front.sv]
// Front end: accept requests, flag byte range, hold a two-entry queue.
module fate_front #(
  parameter int TABLE_BYTES = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  fate_req_if.sink             req,
  input  logic                 pop,
  output fate_pkg::queue_head_t head
);
  import fate_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       incoming;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;

  always_comb begin
    incoming.op            = req.op;
    incoming.byte_address  = req.byte_address;
    incoming.byte_data     = req.byte_data;
    incoming.cluster_index = req.cluster_index;
    incoming.entry_value   = req.entry_value;
    incoming.value_kind    = req.value_kind;
    incoming.byte_range    = (32'(req.byte_address) >= TABLE_BYTES);
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/core/fate_back.sv]
// Back end: sequence table reads and writes, classify entries, scan for free.
module fate_back #(
  parameter int TABLE_BYTES = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            fat_type,
  input  logic [14:0]           cluster_count,
  input  fate_pkg::queue_head_t head,
  output logic                  pop,
  fate_rsp_if.source            rsp
);
  import fate_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  cmd_t        cmd;
  logic [14:0] cur;
  logic [2:0]  cnt;
  logic [31:0] word;
  logic [31:0] nword;
  logic [2:0]  res_status;
  logic [27:0] res_value;
  logic [7:0]  res_byte;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [16:0] off;
  logic [16:0] last;
  logic        fits;
  logic [2:0]  nbytes;
  logic [27:0] entry;
  logic [2:0]  cls;
  logic [27:0] newval;
  logic        take;

  fate_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Start a new transaction only once the response register is free.
  assign take = (state == S_IDLE) && head.valid && (!rsp.valid || rsp.ready);

  // Entry placement for the current index.
  always_comb begin
    case (fat_type)
      FAT12:   off = {2'b0, cur} + {3'b0, cur[14:1]};
      FAT16:   off = {1'b0, cur, 1'b0};
      default: off = {cur, 2'b0};
    endcase
    last   = off + ((fat_type == FAT32) ? 17'd3 : 17'd1);
    nbytes = (fat_type == FAT32) ? 3'd4 : 3'd2;
    fits   = (cur < cluster_count) &&
             ((fat_type == FAT_UNKNOWN) || (32'(last) < TABLE_BYTES));
  end

  // Classify the fetched entry and build the new word for a set.
  always_comb begin
    case (fat_type)
      FAT12: entry = cur[0] ? {16'b0, word[15:4]} : {16'b0, word[11:0]};
      FAT16: entry = {12'b0, word[15:0]};
      default: entry = word[27:0];
    endcase
    cls = ST_LINK;
    case (fat_type)
      FAT12: begin
        if (entry == BAD12) cls = ST_BAD;
        else if (entry >= END12) cls = ST_END;
      end
      FAT16: begin
        if (entry == BAD16) cls = ST_BAD;
        else if (entry >= END16) cls = ST_END;
      end
      default: begin
        if (entry == BAD32) cls = ST_BAD;
        else if (entry >= END32) cls = ST_END;
      end
    endcase
    if (cls == ST_LINK && entry == 28'd0) cls = ST_UNUSED;

    case (cmd.value_kind)
      KIND_BAD:    newval = (fat_type == FAT12) ? BAD12 :
                            (fat_type == FAT16) ? BAD16 : BAD32;
      KIND_END:    newval = (fat_type == FAT12) ? END12 :
                            (fat_type == FAT16) ? END16 : END32;
      KIND_UNUSED: newval = 28'd0;
      default:     newval = cmd.entry_value;
    endcase
    case (fat_type)
      FAT12: nword = cur[0] ? {16'b0, newval[11:0], word[3:0]}
                            : {16'b0, word[15:12], newval[11:0]};
      FAT16: nword = {16'b0, newval[15:0]};
      default: nword = {word[31:28], newval};
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(off + 17'(cnt));
    ram_wdata = nword[7:0];
    pop       = take;
    case (state)
      S_IDLE: begin
        ram_addr  = AW'(head.cmd.byte_address);
        ram_wdata = head.cmd.byte_data;
        ram_we    = take && (head.cmd.op == OP_LOAD) && !head.cmd.byte_range;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        case (cnt[1:0])
          2'd0:    ram_wdata = nword[7:0];
          2'd1:    ram_wdata = nword[15:8];
          2'd2:    ram_wdata = nword[23:16];
          default: ram_wdata = nword[31:24];
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.status        = res_status;
  assign rsp.cluster_value = res_value;
  assign rsp.byte_out      = res_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            cmd        <= head.cmd;
            res_status <= ST_LINK;
            res_value  <= 28'd0;
            res_byte   <= 8'd0;
            cur        <= {1'b0, head.cmd.cluster_index};
            case (head.cmd.op)
              OP_LOAD: begin
                if (head.cmd.byte_range) res_status <= ST_RANGE;
                state <= S_DONE;
              end
              OP_READ: begin
                if (head.cmd.byte_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_BYTE;
                end
              end
              OP_GET, OP_SET: state <= S_CHECK;
              OP_FIND: begin
                cur   <= 15'd2;
                state <= S_CHECK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_BYTE: begin
          res_byte <= ram_rdata;
          state    <= S_DONE;
        end
        S_CHECK: begin
          cnt <= 3'd0;
          if (!fits) begin
            res_status <= (cmd.op == OP_FIND) ? ST_NONE : ST_RANGE;
            state      <= S_DONE;
          end else if (fat_type == FAT_UNKNOWN) begin
            res_status <= (cmd.op == OP_GET) ? ST_END :
                          (cmd.op == OP_FIND) ? ST_NONE : ST_LINK;
            state      <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // Read data is registered, so it arrives in the cycle after its address.
          case (cnt)
            3'd1:    word[7:0]   <= ram_rdata;
            3'd2:    word[15:8]  <= ram_rdata;
            3'd3:    word[23:16] <= ram_rdata;
            3'd4:    word[31:24] <= ram_rdata;
            default: ;
          endcase
          if (cnt == nbytes) begin
            state <= S_EVAL;
          end
          cnt <= cnt + 3'd1;
        end
        S_EVAL: begin
          cnt <= 3'd0;
          case (cmd.op)
            OP_GET: begin
              res_status <= cls;
              res_value  <= (cls == ST_LINK) ? entry : 28'd0;
              state      <= S_DONE;
            end
            OP_SET: state <= S_WRITE;
            default: begin
              if (cls == ST_UNUSED) begin
                res_status <= ST_LINK;
                res_value  <= 28'(cur);
                state      <= S_DONE;
              end else begin
                cur   <= cur + 15'd1;
                state <= S_CHECK;
              end
            end
          endcase
        end
        S_WRITE: begin
          cnt <= cnt + 3'd1;
          if (cnt == nbytes - 3'd1) state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/fat_table_entry_engine.sv]
// Top level of the FAT table entry engine: config registers, front and back.
//
//  channel | role | transaction moves
//  --------+------+----------------------------------------------------
//  req     | sink | op, byte address/data, cluster index, value, kind
//  rsp     | src  | status, cluster value, byte out
//  cfg     | sink | register index and write data (always ready)
//
// Entries are read and written one byte at a time through the single byte port
// of the table RAM: a set writes each byte back after the read, and find free
// reads and classifies each entry it visits in turn, from cluster 2 upward.
// Reset (rst, synchronous) clears control state and the config registers;
// the table RAM is not cleared. The two-entry request queue keeps accepting,
// until full, while the back end works or its response waits on rsp.ready.
module fat_table_entry_engine #(
  parameter int TABLE_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst,
  fate_req_if.sink   req,
  fate_rsp_if.source rsp,
  fate_cfg_if.sink   cfg
);
  import fate_pkg::*;

  logic [1:0]  fat_type;
  logic [14:0] cluster_count;
  queue_head_t head;
  logic        pop;

  // The user must make config writes land only while idle, unchecked here; take them every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_type      <= 2'd0;
      cluster_count <= 15'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FAT_TYPE:      fat_type      <= cfg.data[1:0];
        REG_CLUSTER_COUNT: cluster_count <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: accept and flag requests, buffer them for the back end.
  fate_front #(.TABLE_BYTES(TABLE_BYTES)) u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .pop (pop),
    .head(head)
  );

  // Back: walk the table through the byte RAM and hold the response.
  fate_back #(.TABLE_BYTES(TABLE_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .fat_type     (fat_type),
    .cluster_count(cluster_count),
    .head         (head),
    .pop          (pop),
    .rsp          (rsp)
  );
endmodule
